### hw/rtl/windowed_xy_bounds_tracker_defines.svh
// Assertion macros for the windowed xy bounds tracker checker.
`ifndef WINDOWED_XY_BOUNDS_TRACKER_DEFINES_SVH
`define WINDOWED_XY_BOUNDS_TRACKER_DEFINES_SVH

// Check a property on the rising edge of clk, outside reset.
`define WXYB_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check a property on every rising edge of clk, reset included.
`define WXYB_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/wxyb_pkg.sv
// Shared types and constants of the windowed xy bounds tracker.
`default_nettype none

package wxyb_pkg;

  localparam int STORE_DEPTH = 1024;
  localparam int COORD_W     = 24;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = ADDR_W + 1;
  localparam int CFG_W       = 10;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  localparam logic [CFG_W-1:0]   MAX_POINTS_RESET = CFG_W'(100);
  localparam logic [COUNT_W-1:0] MIN_EFF_POINTS   = COUNT_W'(4);
  localparam logic [COUNT_W-1:0] MAX_EFF_POINTS   = COUNT_W'(STORE_DEPTH - 1);

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic REG_MAX_POINTS = 1'b0;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_low;
    logic signed [COORD_W-1:0] x_high;
    logic signed [COORD_W-1:0] y_low;
    logic signed [COORD_W-1:0] y_high;
  } bounds_t;

endpackage

`default_nettype wire

### hw/rtl/wxyb_if.sv
// Item channel interfaces of the windowed xy bounds tracker.
`default_nettype none

interface wxyb_in_if;
  logic                               valid;
  logic                               ready;
  logic                               op;
  logic signed [wxyb_pkg::COORD_W-1:0] x_value;
  logic signed [wxyb_pkg::COORD_W-1:0] y_value;

  modport source (output valid, op, x_value, y_value, input ready);
  modport sink   (input valid, op, x_value, y_value, output ready);
endinterface

interface wxyb_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [wxyb_pkg::COORD_W-1:0] min_x;
  logic signed [wxyb_pkg::COORD_W-1:0] max_x;
  logic signed [wxyb_pkg::COORD_W-1:0] min_y;
  logic signed [wxyb_pkg::COORD_W-1:0] max_y;
  logic        [wxyb_pkg::COUNT_W-1:0] point_count;
  logic                               trimmed;

  modport source (output valid, min_x, max_x, min_y, max_y, point_count, trimmed,
                  input ready);
  modport sink   (input valid, min_x, max_x, min_y, max_y, point_count, trimmed,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/wxyb_bounds_unit.sv
// Shared min/max compare unit: folds one point into the four bounds, or loads them from it.
`default_nettype none

module wxyb_bounds_unit (
  input  wxyb_pkg::bounds_t                cur,
  input  logic                             load,
  input  logic signed [wxyb_pkg::COORD_W-1:0] px,
  input  logic signed [wxyb_pkg::COORD_W-1:0] py,
  output wxyb_pkg::bounds_t                upd
);

  always_comb begin
    if (load) begin
      upd.x_low  = px;
      upd.x_high = px;
      upd.y_low  = py;
      upd.y_high = py;
    end else begin
      upd.x_low  = (px < cur.x_low)  ? px : cur.x_low;
      upd.x_high = (px > cur.x_high) ? px : cur.x_high;
      upd.y_low  = (py < cur.y_low)  ? py : cur.y_low;
      upd.y_high = (py > cur.y_high) ? py : cur.y_high;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/windowed_xy_bounds_tracker.sv
// Top level of the windowed xy bounds tracker.
// Usage:
//   in_ch  : op (add or clear) and an (x, y) point, valid/ready handshake.
//   out_ch : four bounds, the point count and the trim flag, one item per input.
//   APB    : register 0 at byte 0 is max_points (10 bits, reset 100).
// Timing:
//   A clear or an add without trim goes through the exec and emit steps to a
//   valid result; in_ready rises with the result, so no new item is accepted
//   before it. An add that trims rescans the remaining n points through the
//   store's single registered read port before the emit step.
//   One item at a time; the next item may be accepted while a result waits.
// Reset:
//   rst_n clears the count, the oldest index, the bounds (to zero) and sets
//   max_points to 100. The point store itself is not cleared.
// Stall:
//   While out_ch.ready is low the result holds; a finished item waits in
//   the emit step until the output register is free.
`default_nettype none

module windowed_xy_bounds_tracker (
  input  logic                            clk,
  input  logic                            rst_n,
  wxyb_in_if.sink                         in_ch,
  wxyb_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wxyb_pkg::PADDR_W-1:0]    paddr,
  input  logic [wxyb_pkg::PDATA_W-1:0]    pwdata,
  output logic [wxyb_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);

  localparam int ADDR_W  = wxyb_pkg::ADDR_W;
  localparam int COUNT_W = wxyb_pkg::COUNT_W;
  localparam int COORD_W = wxyb_pkg::COORD_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic [wxyb_pkg::CFG_W-1:0] max_points_r;
  logic                       op_r;
  logic signed [COORD_W-1:0]  x_r, y_r;
  logic [ADDR_W-1:0]          oldest_r, oldest_nxt;
  logic [COUNT_W-1:0]         count_r, count_nxt;
  logic [COUNT_W-1:0]         scan_cnt_r, scan_cnt_nxt;
  logic                       rd_valid_r;
  logic                       trimmed_r, trimmed_nxt;
  wxyb_pkg::bounds_t          bounds_r, bounds_nxt, unit_upd;

  logic                       out_valid_r, out_valid_nxt;
  wxyb_pkg::bounds_t          out_bounds_r;
  logic [COUNT_W-1:0]         out_count_r;
  logic                       out_trimmed_r;
  logic                       out_load;

  logic [2*COORD_W-1:0]       mem [wxyb_pkg::STORE_DEPTH];
  logic [2*COORD_W-1:0]       rd_data_r;
  logic                       mem_we, mem_re;
  logic [ADDR_W-1:0]          wr_addr, rd_addr;

  logic [COUNT_W-1:0]         mp_ext, lim, drop, count_inc;
  logic                       trim, issuing, unit_load;
  logic signed [COORD_W-1:0]  unit_x, unit_y;
  logic                       in_accept, cfg_write;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_accept   = in_ch.valid && in_ch.ready;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[wxyb_pkg::PADDR_W-1] == wxyb_pkg::REG_MAX_POINTS);
  assign prdata    = (paddr[wxyb_pkg::PADDR_W-1] == wxyb_pkg::REG_MAX_POINTS) ?
                     wxyb_pkg::PDATA_W'(max_points_r) : '0;

  assign mp_ext    = COUNT_W'(max_points_r);
  assign lim       = (mp_ext < wxyb_pkg::MIN_EFF_POINTS) ? wxyb_pkg::MIN_EFF_POINTS :
                     (mp_ext > wxyb_pkg::MAX_EFF_POINTS) ? wxyb_pkg::MAX_EFF_POINTS : mp_ext;
  assign drop      = lim >> 2;
  assign count_inc = count_r + COUNT_W'(1);
  assign trim      = (count_inc > lim);

  assign wr_addr = oldest_r + count_r[ADDR_W-1:0];
  assign rd_addr = oldest_r + scan_cnt_r[ADDR_W-1:0];
  assign issuing = (scan_cnt_r < count_r);
  assign mem_we  = (state_r == ST_EXEC) && (op_r == wxyb_pkg::OP_ADD);
  assign mem_re  = (state_r == ST_SCAN) && issuing;

  always_comb begin
    if (state_r == ST_SCAN) begin
      unit_x    = $signed(rd_data_r[2*COORD_W-1:COORD_W]);
      unit_y    = $signed(rd_data_r[COORD_W-1:0]);
      unit_load = 1'b0;
    end else begin
      unit_x    = x_r;
      unit_y    = y_r;
      unit_load = (count_r == '0) || trim;
    end
  end

  wxyb_bounds_unit u_bounds (
    .cur  (bounds_r),
    .load (unit_load),
    .px   (unit_x),
    .py   (unit_y),
    .upd  (unit_upd)
  );

  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    count_nxt     = count_r;
    scan_cnt_nxt  = scan_cnt_r;
    trimmed_nxt   = trimmed_r;
    bounds_nxt    = bounds_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        trimmed_nxt = 1'b0;
        state_nxt   = ST_EMIT;
        if (op_r == wxyb_pkg::OP_CLEAR) begin
          count_nxt  = '0;
          oldest_nxt = '0;
        end else begin
          bounds_nxt = unit_upd;
          if (trim) begin
            trimmed_nxt  = 1'b1;
            oldest_nxt   = oldest_r + drop[ADDR_W-1:0];
            count_nxt    = count_inc - drop;
            scan_cnt_nxt = '0;
            state_nxt    = ST_SCAN;
          end else begin
            count_nxt = count_inc;
          end
        end
      end
      ST_SCAN: begin
        if (mem_re) begin
          scan_cnt_nxt = scan_cnt_r + COUNT_W'(1);
        end
        if (rd_valid_r) begin
          bounds_nxt = unit_upd;
        end
        if (!issuing && !rd_valid_r) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      max_points_r <= wxyb_pkg::MAX_POINTS_RESET;
      oldest_r     <= '0;
      count_r      <= '0;
      scan_cnt_r   <= '0;
      rd_valid_r   <= 1'b0;
      trimmed_r    <= 1'b0;
      bounds_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      oldest_r   <= oldest_nxt;
      count_r    <= count_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      rd_valid_r <= mem_re;
      trimmed_r  <= trimmed_nxt;
      bounds_r   <= bounds_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write) begin
        max_points_r <= pwdata[wxyb_pkg::CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r <= in_ch.op;
      x_r  <= in_ch.x_value;
      y_r  <= in_ch.y_value;
    end
    if (out_load) begin
      out_bounds_r  <= bounds_r;
      out_count_r   <= count_r;
      out_trimmed_r <= trimmed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= {x_r, y_r};
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.min_x       = out_bounds_r.x_low;
  assign out_ch.max_x       = out_bounds_r.x_high;
  assign out_ch.min_y       = out_bounds_r.y_low;
  assign out_ch.max_y       = out_bounds_r.y_high;
  assign out_ch.point_count = out_count_r;
  assign out_ch.trimmed     = out_trimmed_r;

endmodule

`default_nettype wire

### hw/rtl/wxyb_checker.sv
// Port-level assertion checker of the windowed xy bounds tracker, with its bind.
`default_nettype none
`include "windowed_xy_bounds_tracker_defines.svh"

module wxyb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [wxyb_pkg::COORD_W-1:0] min_x,
  input logic signed [wxyb_pkg::COORD_W-1:0] max_x,
  input logic signed [wxyb_pkg::COORD_W-1:0] min_y,
  input logic signed [wxyb_pkg::COORD_W-1:0] max_y,
  input logic [wxyb_pkg::COUNT_W-1:0]    point_count,
  input logic                            trimmed
);

  `WXYB_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `WXYB_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "item accepted while busy")
  `WXYB_ASSERT(a_count_range, out_valid |-> point_count < wxyb_pkg::STORE_DEPTH, "count overflow")
  `WXYB_ASSERT(a_trim_bounds, out_valid && trimmed |-> min_x <= max_x && min_y <= max_y && point_count != '0, "bad bounds after trim")

endmodule

bind windowed_xy_bounds_tracker wxyb_checker u_wxyb_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .min_x       (out_ch.min_x),
  .max_x       (out_ch.max_x),
  .min_y       (out_ch.min_y),
  .max_y       (out_ch.max_y),
  .point_count (out_ch.point_count),
  .trimmed     (out_ch.trimmed)
);

`default_nettype wire
